// ----- hw/rtl/minmax_contrast_stretch_defines.svh -----
// assertion macros for the min-max contrast stretch block
// no dependencies
`ifndef MINMAX_CONTRAST_STRETCH_DEFINES_SVH
`define MINMAX_CONTRAST_STRETCH_DEFINES_SVH

// same-cycle implication
`define MMCS_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication
`define MMCS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/mmcs_pkg.sv -----
// shared types and constants of the min-max contrast stretch block
// no dependencies
`default_nettype none
package mmcs_pkg;
   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_MAP     = 1'b1;
   localparam logic [7:0] BYTE_MAX = 8'd255;

   typedef struct packed {
      logic busy;
      logic dividing;
   } back_status_type;
endpackage
`default_nettype wire

// ----- hw/rtl/minmax_contrast_stretch.sv -----
// Min-max contrast stretch to 8 bits. Measure samples (tuser[0] low) update the running
// minimum and maximum at one per cycle; map samples (tuser[0] high) queue and each gives
// one byte. In the back end a flat-frame map sample goes from IDLE straight to OUT, one
// whose byte saturates passes PREP and CHK, and any other also runs the 8-step restoring
// divider in DIV. A two-entry queue lets measure samples and further map samples be taken
// while the back end divides.
// depends on mmcs_pkg, mmcs_front, mmcs_fifo, mmcs_back and the defines header
`default_nettype none
`include "minmax_contrast_stretch_defines.svh"
module minmax_contrast_stretch #(
   parameter int FRAC_BITS   = 8,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   req_tdata, // sample
   input  wire logic [1:0]                         req_tuser, // command, first_of_frame
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [7:0]                              rsp_tdata, // pixel_byte
   output logic                                    rsp_tuser  // flat_frame
);
   localparam int EW = 2 * SAMPLE_BITS + 11;

   logic                      push_valid, push_ready, pop_valid, pop_ready;
   logic [EW-1:0]             push_data, pop_data;
   mmcs_pkg::back_status_type status;

   mmcs_front #(.FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS), .EW(EW)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .command(req_tuser[0]), .first_of_frame(req_tuser[1]),
      .sample(req_tdata[SAMPLE_BITS-1:0]),
      .q_valid(push_valid), .q_ready(push_ready), .q_data(push_data)
   );

   mmcs_fifo #(.WIDTH(EW)) u_fifo (
      .clock, .reset,
      .push_valid, .push_ready, .push_data,
      .pop_valid, .pop_ready, .pop_data
   );

   mmcs_back #(.SAMPLE_BITS(SAMPLE_BITS), .EW(EW)) u_back (
      .clock, .reset,
      .q_valid(pop_valid), .q_ready(pop_ready), .q_data(pop_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .pixel_byte(rsp_tdata), .flat_frame(rsp_tuser), .status
   );

   `MMCS_ASSERT_NOW(a_no_push_full, clock, reset, push_valid && !push_ready, !req_tready)
   `MMCS_ASSERT_NEXT(a_pop_busy, clock, reset, pop_valid && pop_ready, status.busy)
   `MMCS_ASSERT_NOW(a_result_idle_div, clock, reset, rsp_tvalid, !status.dividing)
endmodule
`default_nettype wire

// ----- hw/rtl/mmcs_fifo.sv -----
// two-entry queue between front and back
// no dependencies
`default_nettype none
module mmcs_fifo #(
   parameter int WIDTH = 75
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/mmcs_front.sv -----
// front: accepts samples, tracks min and max, queues map work
// depends on mmcs_pkg
`default_nettype none
module mmcs_front #(
   parameter int FRAC_BITS   = 8,
   parameter int SAMPLE_BITS = 32,
   parameter int EW          = 2 * SAMPLE_BITS + 11
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic                   command,
   input  wire logic                   first_of_frame,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   output logic                        q_valid,
   input  wire logic                   q_ready,
   output logic [EW-1:0]               q_data
);
   localparam logic signed [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in, base_min, base_max, s;
   logic signed [SAMPLE_BITS:0]   diff, spread;
   logic [SAMPLE_BITS-1:0]        whole;
   logic [7:0]                    flat_byte;
   logic                          flat, accept;

   assign s        = $signed(sample);
   assign in_ready = (command != mmcs_pkg::CMD_MAP) || q_ready;
   assign accept   = in_valid && in_ready;
   assign q_valid  = in_valid && (command == mmcs_pkg::CMD_MAP);

   always_comb begin
      base_min = first_of_frame ? MAX_POS : min_ff;
      base_max = first_of_frame ? '0 : max_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (accept && command == mmcs_pkg::CMD_MEASURE) begin
         min_in = (s < base_min) ? s : base_min;
         max_in = (s > base_max) ? s : base_max;
      end
   end

   always_comb begin
      diff   = {s[SAMPLE_BITS-1], s} - {min_ff[SAMPLE_BITS-1], min_ff};
      spread = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
      flat   = (max_ff == min_ff);
      whole  = $unsigned(min_ff >>> FRAC_BITS);
      if (min_ff[SAMPLE_BITS-1]) flat_byte = 8'd0;
      else if (whole > SAMPLE_BITS'(mmcs_pkg::BYTE_MAX)) flat_byte = mmcs_pkg::BYTE_MAX;
      else flat_byte = whole[7:0];
   end

   assign q_data = {flat, flat_byte, spread, diff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MAX_POS;
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/mmcs_back.sv -----
// back: scales queued samples to bytes with an 8-step restoring divider
// depends on mmcs_pkg
`default_nettype none
module mmcs_back #(
   parameter int SAMPLE_BITS = 32,
   parameter int EW          = 2 * SAMPLE_BITS + 11
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output logic                         q_ready,
   input  wire logic [EW-1:0]           q_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [7:0]                   pixel_byte,
   output logic                         flat_frame,
   output mmcs_pkg::back_status_type    status
);
   localparam int W = SAMPLE_BITS + 12;

   typedef enum logic [2:0] {IDLE, PREP, CHK, DIV, OUT} state_type;

   state_type              state_ff, state_in;
   logic signed [W-1:0]    rem_ff, rem_in, den_ff, den_in;
   logic signed [W-1:0]    diff_w, dist_w, n, dabs;
   logic [SAMPLE_BITS:0]   diff_ff, diff_in, dist_ff, dist_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   flat_ff, flat_in;

   assign q_ready    = (state_ff == IDLE);
   assign out_valid  = (state_ff == OUT);
   assign pixel_byte = byte_ff;
   assign flat_frame = flat_ff;
   assign status.busy     = (state_ff != IDLE);
   assign status.dividing = (state_ff == DIV);

   always_comb begin
      diff_w = W'($signed(diff_ff));
      dist_w = W'($signed(dist_ff));
      n      = (diff_w <<< 8) - diff_w;
      dabs   = dist_w;
      if (dist_w < 0) begin
         n    = -n;
         dabs = -dist_w;
      end
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      diff_in  = diff_ff;
      dist_in  = dist_ff;
      cnt_in   = cnt_ff;
      byte_in  = byte_ff;
      flat_in  = flat_ff;
      case (state_ff)
         IDLE: begin
            if (q_valid) begin
               diff_in = q_data[SAMPLE_BITS:0];
               dist_in = q_data[2*SAMPLE_BITS+1:SAMPLE_BITS+1];
               byte_in = q_data[2*SAMPLE_BITS+9:2*SAMPLE_BITS+2];
               flat_in = q_data[2*SAMPLE_BITS+10];
               state_in = q_data[2*SAMPLE_BITS+10] ? OUT : PREP;
            end
         end
         PREP: begin
            rem_in   = (n <<< 1) + dabs;
            den_in   = dabs <<< 1;
            state_in = CHK;
         end
         CHK: begin
            if (rem_ff < 0) begin
               byte_in  = 8'd0;
               state_in = OUT;
            end else if (rem_ff >= (den_ff <<< 8)) begin
               byte_in  = mmcs_pkg::BYTE_MAX;
               state_in = OUT;
            end else begin
               den_in   = den_ff <<< 7;
               cnt_in   = 3'd7;
               byte_in  = 8'd0;
               state_in = DIV;
            end
         end
         DIV: begin
            if (rem_ff >= den_ff) begin
               rem_in  = rem_ff - den_ff;
               byte_in = {byte_ff[6:0], 1'b1};
            end else begin
               byte_in = {byte_ff[6:0], 1'b0};
            end
            den_in = den_ff >>> 1;
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) state_in = OUT;
         end
         OUT: begin
            if (out_ready) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      diff_ff <= diff_in;
      dist_ff <= dist_in;
      cnt_ff  <= cnt_in;
      byte_ff <= byte_in;
      flat_ff <= flat_in;
   end
endmodule
`default_nettype wire

// ----- sim/tb_minmax_contrast_stretch.sv -----
// self-checking testbench of minmax_contrast_stretch: frames of measure then map transfers,
// results predicted by a scoreboard class and checked in order
// depends on mmcs_pkg and the minmax_contrast_stretch rtl
`timescale 1ns / 100ps

typedef struct {
   logic [7:0] pixel;
   logic       flat;
} stretch_result_type;

class stretch_scoreboard;
   localparam int      FRAC = 8;
   localparam longint  SAMPLE_MAX = 64'sd2147483647;
   longint             frame_min;
   longint             frame_max;
   stretch_result_type pending_bytes[$];
   int                 errors;

   function new();
      frame_min = SAMPLE_MAX;
      frame_max = 0;
      errors    = 0;
   endfunction

   function logic [7:0] saturate(longint v);
      if (v < 0) return 8'd0;
      if (v > mmcs_pkg::BYTE_MAX) return mmcs_pkg::BYTE_MAX;
      return v[7:0];
   endfunction

   function void note_input(logic cmd, logic first, logic signed [31:0] smp);
      longint             s;
      longint             d;
      longint             n;
      longint             q;
      stretch_result_type r;
      s = smp;
      if (cmd == mmcs_pkg::CMD_MEASURE) begin
         if (first) begin
            frame_min = SAMPLE_MAX;
            frame_max = 0;
         end
         if (s < frame_min) frame_min = s;
         if (s > frame_max) frame_max = s;
         return;
      end
      if (frame_max == frame_min) begin
         r.pixel = saturate(frame_min / (longint'(1) << FRAC));
         r.flat  = 1'b1;
      end else begin
         d = frame_max - frame_min;
         n = (s - frame_min) * 255;
         if (d < 0) begin
            d = -d;
            n = -n;
         end
         // round half up as floor((2n + d) / 2d)
         n = 2 * n + d;
         d = 2 * d;
         q = n / d;
         if (n < 0 && q * d != n) q--;
         r.pixel = saturate(q);
         r.flat  = 1'b0;
      end
      pending_bytes.push_back(r);
   endfunction

   task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_result(logic [7:0] pixel, logic flat);
      stretch_result_type r;
      if (pending_bytes.size() == 0) begin
         report_mismatch("unexpected transfer, pixel", pixel, -1);
         return;
      end
      r = pending_bytes.pop_front();
      if (pixel !== r.pixel) report_mismatch("pixel_byte", pixel, r.pixel);
      if (flat !== r.flat) report_mismatch("flat_frame", flat, r.flat);
   endtask

   function int pending();
      return pending_bytes.size();
   endfunction
endclass

module tb_minmax_contrast_stretch;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;  // sample
   logic [1:0]  req_tuser;  // command, first_of_frame
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;  // pixel_byte
   logic        rsp_tuser;  // flat_frame

   stretch_scoreboard sb;
   logic              quiet;
   logic              hold_req;
   int                stall_count;
   int                items_sent;
   logic signed [31:0] frame_samples[$];

   minmax_contrast_stretch dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready = quiet || ($urandom_range(99) >= 18);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count > 3000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task send_item(logic cmd, logic first, logic signed [31:0] smp);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 18) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = smp;
      req_tuser  = {first, cmd};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_input(cmd, first, smp);
      items_sent++;
   endtask

   function logic signed [31:0] pick_sample(int mode, logic signed [31:0] base);
      case (mode)
         0: return $urandom;
         1: return base + $signed($urandom_range(4000)) - 2000;
         2: return base;
         3: return -$signed(32'($urandom_range(32'h7fffffff)));
         default: return $signed($urandom_range(65535));
      endcase
   endfunction

   task run_frame();
      int                 n;
      int                 mode;
      logic signed [31:0] base;
      n    = $urandom_range(20, 1);
      mode = $urandom_range(4);
      base = $urandom;
      frame_samples.delete();
      for (int i = 0; i < n; i++) frame_samples.push_back(pick_sample(mode, base));
      for (int i = 0; i < n; i++) send_item(mmcs_pkg::CMD_MEASURE, i == 0, frame_samples[i]);
      for (int i = 0; i < n; i++) begin
         send_item(mmcs_pkg::CMD_MAP, $urandom_range(9) == 0, frame_samples[i]);
      end
      if ($urandom_range(3) == 0) send_item(mmcs_pkg::CMD_MAP, 1'b0, pick_sample(0, base));
   endtask

   initial begin
      int kind;
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      quiet       = 1'b0;
      hold_req    = 1'b0;
      stall_count = 0;
      items_sent  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: state straight from reset, extremes, flat frames, ignored mark
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sd0);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sh7fffffff);
      send_item(mmcs_pkg::CMD_MEASURE, 1'b1, 32'sh80000000);
      send_item(mmcs_pkg::CMD_MEASURE, 1'b0, 32'sh7fffffff);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sh80000000);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sh7fffffff);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sd0);
      send_item(mmcs_pkg::CMD_MAP, 1'b1, 32'sd12345);
      send_item(mmcs_pkg::CMD_MEASURE, 1'b1, 32'sh7fffffff);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sh7fffffff);
      send_item(mmcs_pkg::CMD_MEASURE, 1'b1, 32'sd0);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sd5);
      send_item(mmcs_pkg::CMD_MEASURE, 1'b1, 32'sd25600);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, -32'sd99);
      send_item(mmcs_pkg::CMD_MEASURE, 1'b1, -32'sd5000);
      send_item(mmcs_pkg::CMD_MEASURE, 1'b0, -32'sd100);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, -32'sd5000);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, -32'sd100);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, 32'sd300);
      send_item(mmcs_pkg::CMD_MAP, 1'b0, -32'sd9000);

      while (items_sent < 1320) begin
         if (items_sent > 300 && items_sent < 500) quiet = 1'b1;
         else quiet = 1'b0;
         if (items_sent > 650 && items_sent < 700 && !hold_req) hold_req = 1'b1;
         if (items_sent > 900 && items_sent < 940) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         kind = $urandom_range(9);
         if (kind < 8) begin
            run_frame();
         end else if (kind == 8) begin
            send_item(mmcs_pkg::CMD_MAP, 1'($urandom_range(1)), $urandom);
         end else begin
            send_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;
      quiet      = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
